@@ hdl/hvc_pkg.sv @@
`default_nettype none

package hvc_pkg;

    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;

    typedef struct packed {
        logic [7:0] name_char;
        logic       end_of_name;
    } t_in_word;

    typedef struct packed {
        logic name_ok;
    } t_out_word;

    // letters, digits and hyphen; the dot is handled on its own
    function automatic logic is_label_byte(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], CHAR_HYPHEN});
    endfunction

endpackage

`default_nettype wire

@@ hdl/hvc_if.sv @@
`default_nettype none

interface hvc_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/hvc_in_reg.sv @@
`default_nettype none

module hvc_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hvc_pkg::t_in_word i_word,
    output logic                   o_valid,
    output hvc_pkg::t_in_word      o_word,
    input  wire logic              i_take
);
    import hvc_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // refill in the same cycle the held word moves on
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end
endmodule

`default_nettype wire

@@ hdl/hvc_check.sv @@
`default_nettype none

module hvc_check #(
    parameter int MAX_NAME_LEN  = 253,
    parameter int MAX_LABEL_LEN = 63
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire hvc_pkg::t_in_word i_word,
    output hvc_pkg::t_out_word     o_verdict
);
    import hvc_pkg::*;

    localparam int NW = $clog2(MAX_NAME_LEN + 2);
    localparam int LW = $clog2(MAX_LABEL_LEN + 2);
    localparam logic [NW-1:0] NAME_LIM  = NW'(MAX_NAME_LEN);
    localparam logic [LW-1:0] LABEL_LIM = LW'(MAX_LABEL_LEN);

    logic [NW-1:0] r_name_count, n_name_count;
    logic [LW-1:0] r_label_count, n_label_count;
    logic          r_prev_hyphen, n_prev_hyphen;
    logic          r_name_bad, n_name_bad;

    logic [NW-1:0] name_step;
    logic [LW-1:0] label_step;
    logic          is_hyphen;
    logic          is_dot;
    logic          bad;

    assign is_hyphen = (i_word.name_char == CHAR_HYPHEN);
    assign is_dot    = (i_word.name_char == CHAR_DOT);

    always_comb begin
        bad        = r_name_bad;
        name_step  = (r_name_count <= NAME_LIM) ? r_name_count + NW'(1) : r_name_count;
        label_step = r_label_count;
        if (name_step > NAME_LIM) begin
            bad = 1'b1;
        end
        if (is_dot) begin
            if (r_label_count == '0 || r_prev_hyphen) begin
                bad = 1'b1;
            end
            label_step = '0;
        end else if (!is_label_byte(i_word.name_char)) begin
            bad = 1'b1;
        end else begin
            if (r_label_count == '0 && is_hyphen) begin
                bad = 1'b1;
            end
            if (r_label_count <= LABEL_LIM) begin
                label_step = r_label_count + LW'(1);
            end
            if (label_step > LABEL_LIM) begin
                bad = 1'b1;
            end
        end

        o_verdict.name_ok = !(bad || is_hyphen);

        n_name_count  = r_name_count;
        n_label_count = r_label_count;
        n_prev_hyphen = r_prev_hyphen;
        n_name_bad    = r_name_bad;
        if (i_fire) begin
            if (i_word.end_of_name) begin
                // clear for the next name
                n_name_count  = '0;
                n_label_count = '0;
                n_prev_hyphen = 1'b0;
                n_name_bad    = 1'b0;
            end else begin
                n_name_count  = name_step;
                n_label_count = label_step;
                n_prev_hyphen = is_hyphen;
                n_name_bad    = bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_count  <= '0;
            r_label_count <= '0;
            r_prev_hyphen <= 1'b0;
            r_name_bad    <= 1'b0;
        end else begin
            r_name_count  <= n_name_count;
            r_label_count <= n_label_count;
            r_prev_hyphen <= n_prev_hyphen;
            r_name_bad    <= n_name_bad;
        end
    end
endmodule

`default_nettype wire

@@ hdl/hvc_out_reg.sv @@
`default_nettype none

module hvc_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire hvc_pkg::t_out_word i_word,
    output logic                    o_free,
    output logic                    o_valid,
    output hvc_pkg::t_out_word      o_word,
    input  wire logic               i_ready
);
    import hvc_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_word <= i_word;
        end
    end
endmodule

`default_nettype wire

@@ hdl/dns_hostname_validator_core.sv @@
`default_nettype none

// Streaming host name checker: one byte per word on i_in, end_of_name set on
// the last byte, and one verdict word on o_out (name_ok) for each name. It
// takes one byte every cycle except while a final byte stalls; the per-name
// counters and flags update once per byte, so that loop sets the rate. A
// verdict is loaded into the result register as its final byte leaves the
// input register. i_in.ready drops only while a final byte waits behind a
// verdict that o_out has not yet taken; non-final bytes never wait on o_out.
module dns_hostname_validator_core #(
    parameter int MAX_NAME_LEN  = 253,
    parameter int MAX_LABEL_LEN = 63
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hvc_if.sink       i_in,
    hvc_if.source     o_out
);
    import hvc_pkg::*;

    logic      held_valid;
    t_in_word  held_word;
    logic      out_free;
    logic      take;
    t_out_word verdict;

    // a final byte advances only when the result register can hold its verdict
    assign take = held_valid && (!held_word.end_of_name || out_free);

    hvc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_word  (i_in.data),
        .o_valid (held_valid),
        .o_word  (held_word),
        .i_take  (take)
    );

    hvc_check #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (take),
        .i_word    (held_word),
        .o_verdict (verdict)
    );

    hvc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && held_word.end_of_name),
        .i_word  (verdict),
        .o_free  (out_free),
        .o_valid (o_out.valid),
        .o_word  (o_out.data),
        .i_ready (o_out.ready)
    );
endmodule

`default_nettype wire

@@ test/dns_hostname_validator_core_tb.sv @@
`default_nettype none

module dns_hostname_validator_core_tb;

    import hvc_pkg::*;

    localparam int NAME_LIMIT   = 253;
    localparam int LABEL_LIMIT  = 63;
    localparam int PHASE_BYTES  = 110;
    localparam int DRAIN_CYCLES = 5000;

    typedef enum {NAME_PLAIN, NAME_LONG, NAME_LONG_LABEL} t_name_kind;

    // one directed word; typed rows carry a verdict that is obvious by eye
    typedef struct {
        logic [7:0] ch;
        bit         last;
        bit         typed;
        bit         ok;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hvc_if #(.t_payload(t_in_word))  in_if ();
    hvc_if #(.t_payload(t_out_word)) out_if ();

    dns_hostname_validator_core #(
        .MAX_NAME_LEN (NAME_LIMIT),
        .MAX_LABEL_LEN(LABEL_LIMIT)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the checker state
    logic [8:0] seen_bytes;
    logic [6:0] label_bytes;
    logic [7:0] last_byte;
    bit         name_broken;

    bit   expected_verdicts[$];
    logic [7:0] name_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int bytes_sent     = 0;
    int names_sent     = 0;
    int ok_seen        = 0;
    int rejected_seen  = 0;

    t_row dir_rows[27] = '{
        '{"a",       1'b1, 1'b1, 1'b1},
        '{CHAR_HYPHEN, 1'b1, 1'b1, 1'b0},
        '{CHAR_DOT,  1'b1, 1'b1, 1'b0},
        '{8'hFF,     1'b1, 1'b1, 1'b0},
        '{8'h00,     1'b1, 1'b1, 1'b0},
        '{"Z",       1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,  1'b1, 1'b1, 1'b1},
        '{"z",       1'b0, 1'b0, 1'b0},
        '{CHAR_HYPHEN, 1'b1, 1'b1, 1'b0},
        '{CHAR_DOT,  1'b0, 1'b0, 1'b0},
        '{"0",       1'b1, 1'b1, 1'b0},
        '{"9",       1'b0, 1'b0, 1'b0},
        '{CHAR_HYPHEN, 1'b0, 1'b0, 1'b0},
        '{"A",       1'b1, 1'b0, 1'b0},
        '{"b",       1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,  1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,  1'b0, 1'b0, 1'b0},
        '{"c",       1'b1, 1'b1, 1'b0},
        '{"q",       1'b0, 1'b0, 1'b0},
        '{CHAR_HYPHEN, 1'b0, 1'b0, 1'b0},
        '{CHAR_DOT,  1'b0, 1'b0, 1'b0},
        '{"r",       1'b1, 1'b1, 1'b0},
        '{CHAR_HYPHEN, 1'b0, 1'b0, 1'b0},
        '{"x",       1'b1, 1'b1, 1'b0},
        '{8'h2F,     1'b1, 1'b1, 1'b0},
        '{8'h7B,     1'b1, 1'b1, 1'b0},
        '{8'h40,     1'b1, 1'b1, 1'b0}
    };

    function automatic bit host_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CHAR_HYPHEN;
    endfunction

    function automatic void clear_name_state();
        seen_bytes  = '0;
        label_bytes = '0;
        last_byte   = '0;
        name_broken = 1'b0;
    endfunction

    // advance the shadow state by one byte; returns 1 when a verdict is due
    function automatic bit track_name_byte(input logic [7:0] c, input bit last,
                                           output bit ok);
        bit bad;
        bad = name_broken;
        ok  = 1'b0;
        if (seen_bytes <= NAME_LIMIT)
            seen_bytes = seen_bytes + 1'b1;
        if (seen_bytes > NAME_LIMIT)
            bad = 1'b1;
        if (c == CHAR_DOT) begin
            if (label_bytes == 0 || last_byte == CHAR_HYPHEN)
                bad = 1'b1;
            label_bytes = '0;
        end else if (!host_byte(c)) begin
            bad = 1'b1;
        end else begin
            if (label_bytes == 0 && c == CHAR_HYPHEN)
                bad = 1'b1;
            if (label_bytes <= LABEL_LIMIT)
                label_bytes = label_bytes + 1'b1;
            if (label_bytes > LABEL_LIMIT)
                bad = 1'b1;
        end
        last_byte   = c;
        name_broken = bad;
        if (!last)
            return 1'b0;
        if (c == CHAR_HYPHEN)
            bad = 1'b1;
        ok = !bad;
        clear_name_state();
        return 1'b1;
    endfunction

    function automatic logic [7:0] alnum_byte();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26)
            return 8'h61 + r[7:0];
        else if (r < 52)
            return 8'h41 + r[7:0] - 8'd26;
        else
            return 8'h30 + r[7:0] - 8'd52;
    endfunction

    // label with alphanumeric ends and an occasional hyphen inside
    function automatic void add_label(input int len);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && i < len - 1 && $urandom_range(0, 7) == 0)
                name_buf.push_back(CHAR_HYPHEN);
            else
                name_buf.push_back(alnum_byte());
        end
    endfunction

    task automatic build_name(input t_name_kind kind);
        int remain;
        int len;
        int pos;
        name_buf.delete();
        case (kind)
            NAME_LONG: begin
                // full labels up to the name limit, straddling it
                remain = NAME_LIMIT - 3 + $urandom_range(0, 6);
                while (remain > 0) begin
                    len = (remain < LABEL_LIMIT) ? remain : LABEL_LIMIT;
                    add_label(len);
                    remain -= len;
                    if (remain > 0) begin
                        name_buf.push_back(CHAR_DOT);
                        remain--;
                    end
                end
            end
            NAME_LONG_LABEL: begin
                if ($urandom_range(0, 1) == 1) begin
                    name_buf.push_back(alnum_byte());
                    name_buf.push_back(CHAR_DOT);
                end
                add_label(LABEL_LIMIT - 3 + $urandom_range(0, 6));
                if ($urandom_range(0, 2) == 0)
                    name_buf.push_back(CHAR_DOT);
            end
            default: begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    if (i > 0)
                        name_buf.push_back(CHAR_DOT);
                    add_label($urandom_range(1, 6));
                end
                if ($urandom_range(0, 4) == 0)
                    name_buf.push_back(CHAR_DOT);
                // break a fraction of the plain names
                if ($urandom_range(0, 3) == 0) begin
                    pos = $urandom_range(0, name_buf.size() - 1);
                    case ($urandom_range(0, 4))
                        0: name_buf[pos] = 8'($urandom_range(0, 255));
                        1: name_buf.push_front(CHAR_HYPHEN);
                        2: name_buf.push_back(CHAR_HYPHEN);
                        3: name_buf.insert(pos, CHAR_DOT);
                        default: name_buf.push_front(CHAR_DOT);
                    endcase
                end
            end
        endcase
    endtask

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] ch, input bit last,
                             input bit typed, input bit typed_ok);
        bit ok;
        while ($urandom_range(1, 100) <= send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.data.name_char   <= ch;
        in_if.data.end_of_name <= last;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        bytes_sent++;
        if (track_name_byte(ch, last, ok)) begin
            names_sent++;
            expected_verdicts.push_back(typed ? typed_ok : ok);
        end
        @(negedge i_clk);
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(1, 100) > recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (out_if.data.name_ok)
                ok_seen++;
            else
                rejected_seen++;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, got name_ok=%0b",
                         $time, out_if.data.name_ok);
                fail_count++;
            end else begin
                if (out_if.data.name_ok !== expected_verdicts[0]) begin
                    $display("%0t: name_ok mismatch, expected %0b, got %0b",
                             $time, expected_verdicts[0], out_if.data.name_ok);
                    fail_count++;
                end
                void'(expected_verdicts.pop_front());
            end
        end
    end

    initial begin
        #400000;
        $display("%0t: timeout with %0d verdicts outstanding", $time,
                 expected_verdicts.size());
        $display("[dns_hostname_validator_core] ERROR");
        $finish;
    end

    initial begin
        int phase_bytes;
        int waited;
        t_name_kind kind;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data       = '0;
        clear_name_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].ok);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            phase_bytes = 0;
            for (int n = 0; phase_bytes < PHASE_BYTES; n++) begin
                // open each phase with a name at the label limit; the last
                // phase also gets one name at the name limit
                if (n == 0)
                    kind = NAME_LONG_LABEL;
                else if (n == 1 && ph == 3)
                    kind = NAME_LONG;
                else if ($urandom_range(0, 49) == 0)
                    kind = NAME_LONG_LABEL;
                else
                    kind = NAME_PLAIN;
                build_name(kind);
                foreach (name_buf[k])
                    send_word(name_buf[k], k == name_buf.size() - 1, 1'b0, 1'b0);
                if (kind != NAME_LONG)
                    phase_bytes += name_buf.size();
            end
        end
        in_if.valid <= 1'b0;

        waited = 0;
        while (expected_verdicts.size() != 0 && waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_verdicts.size() != 0) begin
            $display("%0t: %0d verdicts never arrived, expected %0b first, got none",
                     $time, expected_verdicts.size(), expected_verdicts[0]);
            fail_count++;
        end
        // catch any stray verdict behind the last one
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes in %0d names under four flow-control mixes",
                 bytes_sent, names_sent);
        $display("verdicts: %0d valid, %0d rejected, %0d mismatches",
                 ok_seen, rejected_seen, fail_count);
        if (fail_count == 0)
            $display("[dns_hostname_validator_core] OK");
        else
            $display("[dns_hostname_validator_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
